// File: src/frtcc_pkg.sv
package frtcc_pkg;

   // Default sizing
   localparam int REGION_SLOTS_DEF = 16;
   localparam int PAGE_BYTES_DEF   = 4096;
   localparam int ADDRESS_BITS_DEF = 52;

   // Field widths
   localparam int CMD_W    = 2;
   localparam int TYPE_W   = 8;
   localparam int ATTR_W   = 4;
   localparam int ADDR_W   = 52;
   localparam int PAGES_W  = 40;
   localparam int SLOT_W   = 4;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 5;

   localparam logic [CMD_W-1:0] CMD_ADD     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RESERVE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

   localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
   localparam logic [STATUS_W-1:0] STS_SKIP      = 3'd1;
   localparam logic [STATUS_W-1:0] STS_NO_REGION = 3'd2;
   localparam logic [STATUS_W-1:0] STS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd4;

   localparam logic [ATTR_W-1:0] ATTR_ALL = 4'hF;

   // Usable RAM descriptor types
   localparam logic [TYPE_W-1:0] TYPE_LOADER_CODE  = 8'd1;
   localparam logic [TYPE_W-1:0] TYPE_LOADER_DATA  = 8'd2;
   localparam logic [TYPE_W-1:0] TYPE_BOOT_CODE    = 8'd3;
   localparam logic [TYPE_W-1:0] TYPE_BOOT_DATA    = 8'd4;
   localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 8'd7;

   localparam logic [ADDR_W-1:0] BASE_RESET = 52'h0000000100000;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CHECK,
      S_FIND_RD,
      S_FIND_EV,
      S_PLACE,
      S_MERGE_RD,
      S_MERGE_EV,
      S_KILL,
      S_CARVE,
      S_HOLE_RD,
      S_HOLE_EV,
      S_SPLIT,
      S_TRIM,
      S_READ_RD,
      S_READ_EV,
      S_DONE
   } state_type;

endpackage

// File: src/free_range_table_coalesce_carve_core.sv
// Channel | Direction | Handshake           | Payload
// csr     | in        | valid / ready       | extended_memory_base
// req     | in        | valid / stall (out) | command, mem_type, attr_low, base_address,
//         |           |                     | page_count, slot
// rsp     | out       | valid / stall (in)  | status, region_live, region_start,
//         |           |                     | region_end, live_count
//
// One transaction at a time; a rejected add, an overflowing reserve or an unknown
// command goes from the check state straight to the done state. Each slot visit is
// a read state plus an evaluate state on the single read port of the region memories:
// an add that places a new range runs the find pass and a place step, an add that
// extends a region runs the find pass up to the match and then the folding pass, and a
// reserve runs the find pass, a carve step and, for a hole, an empty-slot pass, split and trim.
// Reset is synchronous and clears only control state; the region memories need no
// clearing pass, since slots at or above the fill count are never read.
// The result register holds a finished transaction while rsp_stall is high, and
// the next request is taken meanwhile; a second result waits in the done state.
module free_range_table_coalesce_carve_core #(
   parameter int REGION_SLOTS = frtcc_pkg::REGION_SLOTS_DEF,
   parameter int PAGE_BYTES   = frtcc_pkg::PAGE_BYTES_DEF,
   parameter int ADDRESS_BITS = frtcc_pkg::ADDRESS_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [frtcc_pkg::ADDR_W-1:0]     csr_extended_memory_base,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [frtcc_pkg::CMD_W-1:0]      req_command,
   input  logic [frtcc_pkg::TYPE_W-1:0]     req_mem_type,
   input  logic [frtcc_pkg::ATTR_W-1:0]     req_attr_low,
   input  logic [frtcc_pkg::ADDR_W-1:0]     req_base_address,
   input  logic [frtcc_pkg::PAGES_W-1:0]    req_page_count,
   input  logic [frtcc_pkg::SLOT_W-1:0]     req_slot,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [frtcc_pkg::STATUS_W-1:0]   rsp_status,
   output logic                             rsp_region_live,
   output logic [frtcc_pkg::ADDR_W-1:0]     rsp_region_start,
   output logic [frtcc_pkg::ADDR_W-1:0]     rsp_region_end,
   output logic [frtcc_pkg::COUNT_W-1:0]    rsp_live_count
);

   localparam int AW    = ADDRESS_BITS;
   localparam int SB    = $clog2(REGION_SLOTS);
   localparam int CW    = $clog2(REGION_SLOTS + 1);
   localparam int PS    = $clog2(PAGE_BYTES);
   localparam int LEN_W = frtcc_pkg::PAGES_W + PS;
   localparam int RAW_W = (LEN_W > frtcc_pkg::ADDR_W) ? LEN_W : frtcc_pkg::ADDR_W;
   localparam int SW    = ((RAW_W > AW) ? RAW_W : AW) + 1;
   localparam logic [CW-1:0] SLOTS_C = CW'(REGION_SLOTS);

   frtcc_pkg::state_type state_ff, state_in;

   logic [frtcc_pkg::CMD_W-1:0]    cmd_ff, cmd_in;
   logic                           type_ok_ff, type_ok_in;
   logic                           attr_ok_ff, attr_ok_in;
   logic [frtcc_pkg::ADDR_W-1:0]   raw_ff, raw_in;
   logic [frtcc_pkg::PAGES_W-1:0]  pages_ff, pages_in;
   logic [frtcc_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [frtcc_pkg::ADDR_W-1:0]   base_ff;
   logic [AW-1:0]                  start_ff, start_in;
   logic [AW-1:0]                  end_ff, end_in;
   logic [CW-1:0]                  idx_ff, idx_in;
   logic [CW-1:0]                  used_ff, used_in;
   logic [CW-1:0]                  live_ff, live_in;
   logic [SB-1:0]                  u_ff, u_in;
   logic [AW-1:0]                  u_low_ff, u_low_in;
   logic [AW-1:0]                  u_high_ff, u_high_in;
   logic [SB-1:0]                  free_ff, free_in;
   logic                           have_free_ff, have_free_in;
   logic [AW-1:0]                  f_low_ff, f_low_in;
   logic [AW-1:0]                  f_high_ff, f_high_in;
   logic [frtcc_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                           res_live_ff, res_live_in;
   logic [AW-1:0]                  res_start_ff, res_start_in;
   logic [AW-1:0]                  res_end_ff, res_end_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [frtcc_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                           rsp_live_ff, rsp_live_in;
   logic [frtcc_pkg::ADDR_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [frtcc_pkg::ADDR_W-1:0]   rsp_end_ff, rsp_end_in;
   logic [frtcc_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // Region memories
   logic [SB-1:0] rd_addr;
   logic          lo_we, hi_we;
   logic [SB-1:0] lo_waddr, hi_waddr;
   logic [AW-1:0] lo_wdata, hi_wdata;
   logic [AW-1:0] lo_rd, hi_rd;

   frtcc_ram #(.WIDTH(AW), .DEPTH(REGION_SLOTS)) u_low_ram (
      .clock  (clock),
      .wr_en  (lo_we),
      .wr_addr(lo_waddr),
      .wr_data(lo_wdata),
      .rd_addr(rd_addr),
      .rd_data(lo_rd)
   );

   frtcc_ram #(.WIDTH(AW), .DEPTH(REGION_SLOTS)) u_high_ram (
      .clock  (clock),
      .wr_en  (hi_we),
      .wr_addr(hi_waddr),
      .wr_data(hi_wdata),
      .rd_addr(rd_addr),
      .rd_data(hi_rd)
   );

   // Range arithmetic on the captured request
   logic [SW-1:0] start_ext, len_ext, sum_ext, mask_ext, base_ext;
   logic          range_ovf, below_base;

   assign start_ext  = SW'(raw_ff);
   assign len_ext    = SW'(pages_ff) << PS;
   assign sum_ext    = start_ext + len_ext;
   assign mask_ext   = SW'({AW{1'b1}});
   assign base_ext   = SW'(base_ff);
   assign range_ovf  = (start_ext > mask_ext) || (sum_ext > mask_ext);
   assign below_base = sum_ext < base_ext;

   // Scan conditions
   logic          scan_more, slot_ok, room, hi_zero, at_u, contains;
   logic [SB-1:0] cur;

   assign cur       = idx_ff[SB-1:0];
   assign scan_more = idx_ff < used_ff;
   assign slot_ok   = int'(slot_ff) < int'(used_ff);
   assign room      = used_ff < SLOTS_C;
   assign hi_zero   = hi_rd == '0;
   assign at_u      = cur == u_ff;
   assign contains  = !hi_zero && (start_ff >= lo_rd) && (end_ff <= hi_rd);

   assign req_stall = state_ff != frtcc_pkg::S_IDLE;
   assign csr_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         frtcc_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = frtcc_pkg::S_CHECK;
            end
         end
         frtcc_pkg::S_CHECK: begin
            unique case (cmd_ff)
               frtcc_pkg::CMD_ADD: begin
                  if (!attr_ok_ff || !type_ok_ff || range_ovf || below_base) begin
                     state_in = frtcc_pkg::S_DONE;
                  end else begin
                     state_in = frtcc_pkg::S_FIND_RD;
                  end
               end
               frtcc_pkg::CMD_RESERVE: begin
                  state_in = range_ovf ? frtcc_pkg::S_DONE : frtcc_pkg::S_FIND_RD;
               end
               frtcc_pkg::CMD_READ: begin
                  state_in = slot_ok ? frtcc_pkg::S_READ_RD : frtcc_pkg::S_DONE;
               end
               default: state_in = frtcc_pkg::S_DONE;
            endcase
         end
         frtcc_pkg::S_FIND_RD: begin
            if (scan_more) begin
               state_in = frtcc_pkg::S_FIND_EV;
            end else if (cmd_ff == frtcc_pkg::CMD_ADD) begin
               state_in = frtcc_pkg::S_PLACE;
            end else begin
               state_in = frtcc_pkg::S_DONE;
            end
         end
         frtcc_pkg::S_FIND_EV: begin
            if (cmd_ff == frtcc_pkg::CMD_ADD) begin
               if (!hi_zero && (hi_rd == start_ff || lo_rd == end_ff)) begin
                  state_in = frtcc_pkg::S_MERGE_RD;
               end else begin
                  state_in = frtcc_pkg::S_FIND_RD;
               end
            end else begin
               state_in = contains ? frtcc_pkg::S_CARVE : frtcc_pkg::S_FIND_RD;
            end
         end
         frtcc_pkg::S_PLACE: state_in = frtcc_pkg::S_DONE;
         frtcc_pkg::S_MERGE_RD: begin
            state_in = scan_more ? frtcc_pkg::S_MERGE_EV : frtcc_pkg::S_DONE;
         end
         frtcc_pkg::S_MERGE_EV: begin
            if (!hi_zero && !at_u && (hi_rd == u_low_ff || lo_rd == u_high_ff)) begin
               state_in = frtcc_pkg::S_KILL;
            end else begin
               state_in = frtcc_pkg::S_MERGE_RD;
            end
         end
         frtcc_pkg::S_KILL: state_in = frtcc_pkg::S_DONE;
         frtcc_pkg::S_CARVE: begin
            if (start_ff > f_low_ff && end_ff < f_high_ff) begin
               state_in = frtcc_pkg::S_HOLE_RD;
            end else begin
               state_in = frtcc_pkg::S_DONE;
            end
         end
         frtcc_pkg::S_HOLE_RD: begin
            if (scan_more) begin
               state_in = frtcc_pkg::S_HOLE_EV;
            end else begin
               state_in = room ? frtcc_pkg::S_SPLIT : frtcc_pkg::S_DONE;
            end
         end
         frtcc_pkg::S_HOLE_EV: begin
            state_in = hi_zero ? frtcc_pkg::S_SPLIT : frtcc_pkg::S_HOLE_RD;
         end
         frtcc_pkg::S_SPLIT: state_in = frtcc_pkg::S_TRIM;
         frtcc_pkg::S_TRIM: state_in = frtcc_pkg::S_DONE;
         frtcc_pkg::S_READ_RD: state_in = frtcc_pkg::S_READ_EV;
         frtcc_pkg::S_READ_EV: state_in = frtcc_pkg::S_DONE;
         frtcc_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = frtcc_pkg::S_IDLE;
            end
         end
         default: state_in = frtcc_pkg::S_IDLE;
      endcase
   end

   // Datapath and memory control
   always_comb begin
      cmd_in       = cmd_ff;
      type_ok_in   = type_ok_ff;
      attr_ok_in   = attr_ok_ff;
      raw_in       = raw_ff;
      pages_in     = pages_ff;
      slot_in      = slot_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      live_in      = live_ff;
      u_in         = u_ff;
      u_low_in     = u_low_ff;
      u_high_in    = u_high_ff;
      free_in      = free_ff;
      have_free_in = have_free_ff;
      f_low_in     = f_low_ff;
      f_high_in    = f_high_ff;
      status_in    = status_ff;
      res_live_in  = res_live_ff;
      res_start_in = res_start_ff;
      res_end_in   = res_end_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_live_in  = rsp_live_ff;
      rsp_start_in = rsp_start_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_count_in = rsp_count_ff;
      rd_addr      = cur;
      lo_we        = 1'b0;
      hi_we        = 1'b0;
      lo_waddr     = cur;
      hi_waddr     = cur;
      lo_wdata     = '0;
      hi_wdata     = '0;

      unique case (state_ff)
         frtcc_pkg::S_IDLE: begin
            // capture the request fields
            cmd_in     = req_command;
            attr_ok_in = req_attr_low == frtcc_pkg::ATTR_ALL;
            type_ok_in = (req_mem_type == frtcc_pkg::TYPE_LOADER_CODE)
                      || (req_mem_type == frtcc_pkg::TYPE_LOADER_DATA)
                      || (req_mem_type == frtcc_pkg::TYPE_BOOT_CODE)
                      || (req_mem_type == frtcc_pkg::TYPE_BOOT_DATA)
                      || (req_mem_type == frtcc_pkg::TYPE_CONVENTIONAL);
            raw_in     = req_base_address;
            pages_in   = req_page_count;
            slot_in    = req_slot;
         end
         frtcc_pkg::S_CHECK: begin
            idx_in       = '0;
            have_free_in = 1'b0;
            res_live_in  = 1'b0;
            res_start_in = '0;
            res_end_in   = '0;
            status_in    = frtcc_pkg::STS_OK;
            end_in       = sum_ext[AW-1:0];
            start_in     = start_ext[AW-1:0];
            unique case (cmd_ff)
               frtcc_pkg::CMD_ADD: begin
                  if (!attr_ok_ff || !type_ok_ff) begin
                     status_in = frtcc_pkg::STS_SKIP;
                  end else if (range_ovf) begin
                     status_in = frtcc_pkg::STS_OVERFLOW;
                  end else if (below_base) begin
                     status_in = frtcc_pkg::STS_SKIP;
                  end else if (start_ext < base_ext) begin
                     // raise the start to the usable base
                     start_in = base_ext[AW-1:0];
                  end
               end
               frtcc_pkg::CMD_RESERVE: begin
                  if (range_ovf) begin
                     status_in = frtcc_pkg::STS_OVERFLOW;
                  end
               end
               default: begin
               end
            endcase
         end
         frtcc_pkg::S_FIND_RD: begin
            if (!scan_more && cmd_ff == frtcc_pkg::CMD_RESERVE) begin
               status_in = frtcc_pkg::STS_NO_REGION;
            end
         end
         frtcc_pkg::S_FIND_EV: begin
            idx_in = idx_ff + CW'(1);
            if (cmd_ff == frtcc_pkg::CMD_ADD) begin
               if (hi_zero) begin
                  // remember the last empty slot
                  free_in      = cur;
                  have_free_in = 1'b1;
               end else if (hi_rd == start_ff) begin
                  hi_we     = 1'b1;
                  hi_wdata  = end_ff;
                  u_in      = cur;
                  u_low_in  = lo_rd;
                  u_high_in = end_ff;
                  idx_in    = '0;
               end else if (lo_rd == end_ff) begin
                  lo_we     = 1'b1;
                  lo_wdata  = start_ff;
                  u_in      = cur;
                  u_low_in  = start_ff;
                  u_high_in = hi_rd;
                  idx_in    = '0;
               end
            end else if (contains) begin
               u_in      = cur;
               f_low_in  = lo_rd;
               f_high_in = hi_rd;
            end
         end
         frtcc_pkg::S_PLACE: begin
            if (have_free_ff || room) begin
               lo_we    = 1'b1;
               hi_we    = 1'b1;
               lo_waddr = have_free_ff ? free_ff : used_ff[SB-1:0];
               hi_waddr = have_free_ff ? free_ff : used_ff[SB-1:0];
               lo_wdata = start_ff;
               hi_wdata = end_ff;
               if (!have_free_ff) begin
                  used_in = used_ff + CW'(1);
               end
               // an empty range ending at zero stays dead
               if (end_ff != '0) begin
                  live_in = live_ff + CW'(1);
               end
            end else begin
               status_in = frtcc_pkg::STS_FULL;
            end
         end
         frtcc_pkg::S_MERGE_EV: begin
            idx_in = idx_ff + CW'(1);
            if (!hi_zero && !at_u) begin
               if (hi_rd == u_low_ff) begin
                  hi_we    = 1'b1;
                  hi_wdata = u_high_ff;
               end else if (lo_rd == u_high_ff) begin
                  lo_we    = 1'b1;
                  lo_wdata = u_low_ff;
               end
            end
         end
         frtcc_pkg::S_KILL: begin
            // drop the region folded into its neighbor
            hi_we    = 1'b1;
            hi_waddr = u_ff;
            hi_wdata = '0;
            live_in  = live_ff - CW'(1);
         end
         frtcc_pkg::S_CARVE: begin
            idx_in   = '0;
            lo_waddr = u_ff;
            hi_waddr = u_ff;
            if (start_ff > f_low_ff) begin
               if (end_ff >= f_high_ff) begin
                  hi_we    = 1'b1;
                  hi_wdata = start_ff;
               end
            end else if (end_ff < f_high_ff) begin
               lo_we    = 1'b1;
               lo_wdata = end_ff;
            end else begin
               lo_we    = 1'b1;
               hi_we    = 1'b1;
               lo_wdata = '0;
               hi_wdata = '0;
               live_in  = live_ff - CW'(1);
            end
         end
         frtcc_pkg::S_HOLE_RD: begin
            if (!scan_more) begin
               if (room) begin
                  free_in = used_ff[SB-1:0];
                  used_in = used_ff + CW'(1);
               end else begin
                  status_in = frtcc_pkg::STS_FULL;
               end
            end
         end
         frtcc_pkg::S_HOLE_EV: begin
            idx_in = idx_ff + CW'(1);
            if (hi_zero) begin
               free_in = cur;
            end
         end
         frtcc_pkg::S_SPLIT: begin
            lo_we    = 1'b1;
            hi_we    = 1'b1;
            lo_waddr = free_ff;
            hi_waddr = free_ff;
            lo_wdata = end_ff;
            hi_wdata = f_high_ff;
            live_in  = live_ff + CW'(1);
         end
         frtcc_pkg::S_TRIM: begin
            hi_we    = 1'b1;
            hi_waddr = u_ff;
            hi_wdata = start_ff;
         end
         frtcc_pkg::S_READ_RD: begin
            rd_addr = SB'(slot_ff);
         end
         frtcc_pkg::S_READ_EV: begin
            if (!hi_zero) begin
               res_live_in  = 1'b1;
               res_start_in = lo_rd;
               res_end_in   = hi_rd;
            end
         end
         frtcc_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_live_in   = res_live_ff;
               rsp_start_in  = frtcc_pkg::ADDR_W'(res_start_ff);
               rsp_end_in    = frtcc_pkg::ADDR_W'(res_end_ff);
               rsp_count_in  = frtcc_pkg::COUNT_W'(live_ff);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= frtcc_pkg::S_IDLE;
         used_ff      <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= frtcc_pkg::BASE_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         live_ff      <= live_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            base_ff <= csr_extended_memory_base;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      type_ok_ff    <= type_ok_in;
      attr_ok_ff    <= attr_ok_in;
      raw_ff        <= raw_in;
      pages_ff      <= pages_in;
      slot_ff       <= slot_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      idx_ff        <= idx_in;
      u_ff          <= u_in;
      u_low_ff      <= u_low_in;
      u_high_ff     <= u_high_in;
      free_ff       <= free_in;
      have_free_ff  <= have_free_in;
      f_low_ff      <= f_low_in;
      f_high_ff     <= f_high_in;
      status_ff     <= status_in;
      res_live_ff   <= res_live_in;
      res_start_ff  <= res_start_in;
      res_end_ff    <= res_end_in;
      rsp_status_ff <= rsp_status_in;
      rsp_live_ff   <= rsp_live_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_region_live  = rsp_live_ff;
   assign rsp_region_start = rsp_start_ff;
   assign rsp_region_end   = rsp_end_ff;
   assign rsp_live_count   = rsp_count_ff;

endmodule

// File: src/frtcc_ram.sv
module frtcc_ram #(
   parameter int WIDTH = 52,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
